// ----- rtl/core/nearest_path_edge_search_core_assert.svh -----
// Assertion macros for the nearest path edge search core.
// Used inside modules that have clk and arst_n in scope.
`ifndef NEAREST_PATH_EDGE_SEARCH_CORE_ASSERT_SVH
`define NEAREST_PATH_EDGE_SEARCH_CORE_ASSERT_SVH

// same-cycle implication, off during reset
`define NPES_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("npes: same-cycle check failed");

// next-cycle implication, off during reset
`define NPES_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("npes: next-cycle check failed");

`endif

// ----- rtl/core/npes_pkg.sv -----
// Shared types and constants for the nearest path edge search core.
// No dependencies; used by npes_mac, npes_div and the top level.
package npes_pkg;

	localparam int COORD_BITS   = 16;
	localparam int MAX_VERTICES = 4096;

	localparam int DIFF_W  = COORD_BITS + 1;  // coordinate difference
	localparam int DIST_W  = 36;              // squared distance, squared length
	localparam int DOT_W   = DIST_W + 1;      // signed projection dot
	localparam int HALF_W  = DIST_W / 2;      // dot split for squaring
	localparam int MUL_W   = HALF_W + 1;      // signed multiplier operand
	localparam int PROD_W  = 2 * MUL_W;
	localparam int ACC_W   = 2 * DIST_W;      // holds dot^2
	localparam int IDX_W   = 12;
	localparam int CNT_W   = IDX_W + 1;
	localparam int STEP_W  = 4;
	localparam int DIV_STEPS = DIST_W;
	localparam int DIV_CNT_W = $clog2(DIV_STEPS);

	localparam int SH_MID_BITS  = HALF_W + 1; // 2*H*L*2^18 == H*L << 19
	localparam int SH_HIGH_BITS = 2 * HALF_W;

	// sequencer steps of the shared multiplier
	localparam logic [STEP_W-1:0] STEP_BASE_LAST = STEP_W'(11);
	localparam logic [STEP_W-1:0] STEP_SQ_FIRST  = STEP_W'(12);
	localparam logic [STEP_W-1:0] STEP_SQ_LAST   = STEP_W'(14);

	typedef struct packed {
		logic signed [COORD_BITS-1:0] vertex_x;
		logic signed [COORD_BITS-1:0] vertex_y;
		logic signed [COORD_BITS-1:0] vertex_z;
		logic signed [COORD_BITS-1:0] query_x;
		logic signed [COORD_BITS-1:0] query_y;
		logic signed [COORD_BITS-1:0] query_z;
		logic first_point;
		logic last_point;
	} in_word_t;

	typedef struct packed {
		logic              found;
		logic [IDX_W-1:0]  nearest_edge;
		logic [DIST_W-1:0] distance_squared;
		logic              overflow;
	} out_word_t;

	typedef struct packed {
		logic signed [COORD_BITS-1:0] x;
		logic signed [COORD_BITS-1:0] y;
		logic signed [COORD_BITS-1:0] z;
	} pt_t;

	typedef struct packed {
		logic signed [DIFF_W-1:0] x;
		logic signed [DIFF_W-1:0] y;
		logic signed [DIFF_W-1:0] z;
	} dif_t;

	typedef enum logic [1:0] {
		SH_NONE,
		SH_MID,
		SH_HIGH
	} sh_t;

	typedef enum logic [2:0] {
		DST_LEN,
		DST_DOT,
		DST_DD,
		DST_DB,
		DST_NUM
	} dst_t;

	typedef struct packed {
		logic vld;
		logic first;
		logic last;
		sh_t  sh;
		dst_t dest;
	} mac_ctl_t;

	typedef struct packed {
		logic done;
		dst_t dest;
	} mac_stat_t;

	typedef struct packed {
		logic busy;
		logic done;
	} div_stat_t;

	function automatic logic signed [MUL_W-1:0] ext_mul(input logic signed [DIFF_W-1:0] v);
		return MUL_W'(v);
	endfunction

	function automatic dif_t sub_pt(input pt_t p, input pt_t q);
		dif_t r;
		r.x = {p.x[COORD_BITS-1], p.x} - {q.x[COORD_BITS-1], q.x};
		r.y = {p.y[COORD_BITS-1], p.y} - {q.y[COORD_BITS-1], q.y};
		r.z = {p.z[COORD_BITS-1], p.z} - {q.z[COORD_BITS-1], q.z};
		return r;
	endfunction

endpackage

// ----- rtl/core/npes_mac.sv -----
// Shared multiply-accumulate unit: one signed multiplier, registered product,
// shifted 72-bit accumulate. Depends on npes_pkg.
module npes_mac (
	input  logic                               clk,
	input  logic                               arst_n,
	input  npes_pkg::mac_ctl_t                 ctl,
	input  logic signed [npes_pkg::MUL_W-1:0]  op_a,
	input  logic signed [npes_pkg::MUL_W-1:0]  op_b,
	output npes_pkg::mac_stat_t                stat,
	output logic signed [npes_pkg::ACC_W-1:0]  acc
);
	import npes_pkg::*;

	logic signed [PROD_W-1:0] prod_s1;
	mac_ctl_t                 ctl_s1;
	logic signed [ACC_W-1:0]  acc_q;
	logic signed [ACC_W-1:0]  prod_ext;
	logic signed [ACC_W-1:0]  prod_sh;
	logic signed [ACC_W-1:0]  acc_nxt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1 <= '0;
		end else begin
			ctl_s1 <= ctl;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.vld) begin
			prod_s1 <= op_a * op_b;
		end
		if (ctl_s1.vld) begin
			acc_q <= acc_nxt;
		end
	end

	always_comb begin
		prod_ext = ACC_W'(prod_s1);
		case (ctl_s1.sh)
			SH_MID:  prod_sh = prod_ext <<< SH_MID_BITS;
			SH_HIGH: prod_sh = prod_ext <<< SH_HIGH_BITS;
			default: prod_sh = prod_ext;
		endcase
		acc_nxt = (ctl_s1.first ? '0 : acc_q) + prod_sh;
	end

	assign stat.done = ctl_s1.vld && ctl_s1.last;
	assign stat.dest = ctl_s1.dest;
	assign acc       = acc_nxt;

endmodule

// ----- rtl/core/npes_div.sv -----
// Restoring divider, one quotient bit per cycle: floor(num / den) where the
// quotient fits DIST_W bits. Depends on npes_pkg.
module npes_div (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	input  logic [npes_pkg::ACC_W-1:0]   num,
	input  logic [npes_pkg::DIST_W-1:0]  den,
	output npes_pkg::div_stat_t          stat,
	output logic [npes_pkg::DIST_W-1:0]  quot
);
	import npes_pkg::*;

	logic                 busy_q;
	logic                 done_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic [DIST_W-1:0]    rem_q;
	logic [DIST_W-1:0]    low_q;
	logic [DIST_W:0]      trial;
	logic [DIST_W:0]      diff;
	logic                 ge;
	logic                 last_step;

	// remainder stays below den, so one compare and subtract per bit
	assign trial = {rem_q, low_q[DIST_W-1]};
	assign diff  = trial - {1'b0, den};
	assign ge    = trial >= {1'b0, den};

	assign last_step = busy_q && !start && (cnt_q == DIV_CNT_W'(DIV_STEPS - 1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= last_step;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (last_step) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= num[ACC_W-1:DIST_W];
			low_q <= num[DIST_W-1:0];
		end else if (busy_q) begin
			rem_q <= ge ? diff[DIST_W-1:0] : trial[DIST_W-1:0];
			low_q <= {low_q[DIST_W-2:0], ge};
		end
	end

	assign stat.busy = busy_q;
	assign stat.done = done_q;
	assign quot      = low_q;

endmodule

// ----- rtl/core/nearest_path_edge_search_core.sv -----
// Nearest path edge search. Vertices of a path arrive one word at a time; each
// new vertex closes an edge whose exact squared distance to the query point is
// found with one shared 19x19 multiplier under a sequencer (15 products) and a
// 36-step bit-serial divider for the interior case. A vertex that only starts a
// path or is past capacity goes to the tail state; an endpoint edge runs the
// diff, multiply, drain, pick and update states; an interior edge also runs
// the squaring products, divider and subtract. With the closed flag set, the
// last vertex runs one more edge pass. The input is not ready while an edge is
// in work; the result sits in an output register, so the next path may start
// while it waits. Depends on npes_pkg, npes_mac, npes_div and the assert header.
`include "nearest_path_edge_search_core_assert.svh"

module nearest_path_edge_search_core (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_we,
	input  logic                cfg_wdata,
	input  logic                in_valid,
	output logic                in_ready,
	input  npes_pkg::in_word_t  in_word,
	output logic                out_valid,
	input  logic                out_ready,
	output npes_pkg::out_word_t out_word
);
	import npes_pkg::*;

	typedef enum logic [8:0] {
		S_IDLE  = 9'b000000001,
		S_DIFF  = 9'b000000010,
		S_MUL   = 9'b000000100,
		S_DRAIN = 9'b000001000,
		S_PICK  = 9'b000010000,
		S_DIV   = 9'b000100000,
		S_SUB   = 9'b001000000,
		S_UPD   = 9'b010000000,
		S_TAIL  = 9'b100000000
	} st_t;

	st_t               state_q;
	logic [STEP_W-1:0] step_q;
	logic [CNT_W-1:0]  count_q;
	logic              ovf_q;
	logic              last_q;
	logic              closing_q;
	logic              closed_q;
	logic              out_valid_q;
	logic [DIST_W-1:0] best_dist_q;
	logic [IDX_W-1:0]  best_edge_q;

	pt_t               query_q;
	pt_t               start_q;
	pt_t               prev_q;
	pt_t               edge_a_q;
	pt_t               edge_b_q;
	logic [IDX_W-1:0]  edge_idx_q;
	dif_t              d_q;
	dif_t              e_q;
	dif_t              f_q;
	logic [DIST_W-1:0] len2_q;
	logic signed [DOT_W-1:0] dot_q;
	logic [DIST_W-1:0] dd_q;
	logic [DIST_W-1:0] db_q;
	logic [DIST_W-1:0] res_q;
	out_word_t         out_word_q;

	pt_t               in_vtx;
	pt_t               in_qry;
	logic              in_acc;
	logic              start_path;
	logic              take_vtx;
	logic              close_go;
	logic              out_free;
	logic              out_load;
	logic              found;
	logic              dot_nonpos;
	logic              dot_past;

	mac_ctl_t                 mac_ctl;
	mac_stat_t                mac_stat;
	logic signed [MUL_W-1:0]  op_a;
	logic signed [MUL_W-1:0]  op_b;
	logic signed [ACC_W-1:0]  mac_acc;
	div_stat_t                div_stat;
	logic [DIST_W-1:0]        quot;
	logic                     div_start;
	logic signed [MUL_W-1:0]  dot_hi;
	logic signed [MUL_W-1:0]  dot_lo;

	assign in_vtx = '{x: in_word.vertex_x, y: in_word.vertex_y, z: in_word.vertex_z};
	assign in_qry = '{x: in_word.query_x, y: in_word.query_y, z: in_word.query_z};

	assign in_ready   = (state_q == S_IDLE);
	assign in_acc     = in_valid && in_ready;
	assign start_path = in_acc && (in_word.first_point || count_q == '0);
	assign take_vtx   = in_acc && !start_path && (count_q < CNT_W'(MAX_VERTICES));

	assign found    = (count_q >= CNT_W'(2));
	assign close_go = (state_q == S_TAIL) && last_q && closed_q && found && !closing_q;
	assign out_free = !out_valid_q || out_ready;
	assign out_load = (state_q == S_TAIL) && last_q && !close_go && out_free;

	assign dot_nonpos = dot_q[DOT_W-1] || (dot_q == '0);
	assign dot_past   = (dot_q[DIST_W-1:0] >= len2_q);

	// halves of a positive dot below 2^36 for the square
	assign dot_hi = {1'b0, dot_q[DIST_W-1:HALF_W]};
	assign dot_lo = {1'b0, dot_q[HALF_W-1:0]};

	// operand sequence of the shared multiplier
	always_comb begin
		mac_ctl.vld   = (state_q == S_MUL);
		mac_ctl.first = 1'b0;
		mac_ctl.last  = 1'b0;
		mac_ctl.sh    = SH_NONE;
		mac_ctl.dest  = DST_LEN;
		op_a = '0;
		op_b = '0;
		case (step_q)
			4'd0: begin
				op_a = ext_mul(e_q.x); op_b = ext_mul(e_q.x); mac_ctl.first = 1'b1;
			end
			4'd1: begin
				op_a = ext_mul(e_q.y); op_b = ext_mul(e_q.y);
			end
			4'd2: begin
				op_a = ext_mul(e_q.z); op_b = ext_mul(e_q.z); mac_ctl.last = 1'b1;
			end
			4'd3: begin
				op_a = ext_mul(d_q.x); op_b = ext_mul(e_q.x); mac_ctl.first = 1'b1;
				mac_ctl.dest = DST_DOT;
			end
			4'd4: begin
				op_a = ext_mul(d_q.y); op_b = ext_mul(e_q.y); mac_ctl.dest = DST_DOT;
			end
			4'd5: begin
				op_a = ext_mul(d_q.z); op_b = ext_mul(e_q.z); mac_ctl.last = 1'b1;
				mac_ctl.dest = DST_DOT;
			end
			4'd6: begin
				op_a = ext_mul(d_q.x); op_b = ext_mul(d_q.x); mac_ctl.first = 1'b1;
				mac_ctl.dest = DST_DD;
			end
			4'd7: begin
				op_a = ext_mul(d_q.y); op_b = ext_mul(d_q.y); mac_ctl.dest = DST_DD;
			end
			4'd8: begin
				op_a = ext_mul(d_q.z); op_b = ext_mul(d_q.z); mac_ctl.last = 1'b1;
				mac_ctl.dest = DST_DD;
			end
			4'd9: begin
				op_a = ext_mul(f_q.x); op_b = ext_mul(f_q.x); mac_ctl.first = 1'b1;
				mac_ctl.dest = DST_DB;
			end
			4'd10: begin
				op_a = ext_mul(f_q.y); op_b = ext_mul(f_q.y); mac_ctl.dest = DST_DB;
			end
			4'd11: begin
				op_a = ext_mul(f_q.z); op_b = ext_mul(f_q.z); mac_ctl.last = 1'b1;
				mac_ctl.dest = DST_DB;
			end
			4'd12: begin
				op_a = dot_hi; op_b = dot_hi; mac_ctl.first = 1'b1;
				mac_ctl.sh = SH_HIGH; mac_ctl.dest = DST_NUM;
			end
			4'd13: begin
				op_a = dot_hi; op_b = dot_lo; mac_ctl.sh = SH_MID; mac_ctl.dest = DST_NUM;
			end
			4'd14: begin
				op_a = dot_lo; op_b = dot_lo; mac_ctl.last = 1'b1; mac_ctl.dest = DST_NUM;
			end
			default: begin
				mac_ctl.vld = 1'b0;
			end
		endcase
	end

	npes_mac u_mac (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (mac_ctl),
		.op_a   (op_a),
		.op_b   (op_b),
		.stat   (mac_stat),
		.acc    (mac_acc)
	);

	// dot^2 goes straight from the accumulator into the divider
	assign div_start = mac_stat.done && (mac_stat.dest == DST_NUM);

	npes_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (mac_acc),
		.den    (len2_q),
		.stat   (div_stat),
		.quot   (quot)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			step_q      <= '0;
			count_q     <= '0;
			ovf_q       <= 1'b0;
			last_q      <= 1'b0;
			closing_q   <= 1'b0;
			closed_q    <= 1'b0;
			out_valid_q <= 1'b0;
			best_dist_q <= '0;
			best_edge_q <= '0;
		end else begin
			if (cfg_we) begin
				closed_q <= cfg_wdata;
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (in_acc) begin
						last_q <= in_word.last_point;
						if (start_path) begin
							count_q     <= CNT_W'(1);
							best_dist_q <= '0;
							best_edge_q <= '0;
							ovf_q       <= 1'b0;
							closing_q   <= 1'b0;
							state_q     <= S_TAIL;
						end else if (take_vtx) begin
							count_q <= count_q + 1'b1;
							state_q <= S_DIFF;
						end else begin
							ovf_q   <= 1'b1;
							state_q <= S_TAIL;
						end
					end
				end
				S_DIFF: begin
					step_q  <= '0;
					state_q <= S_MUL;
				end
				S_MUL: begin
					if (step_q == STEP_BASE_LAST || step_q == STEP_SQ_LAST) begin
						state_q <= S_DRAIN;
					end else begin
						step_q <= step_q + 1'b1;
					end
				end
				S_DRAIN: begin
					state_q <= (step_q == STEP_SQ_LAST) ? S_DIV : S_PICK;
				end
				S_PICK: begin
					if ((len2_q == '0) || dot_nonpos || dot_past) begin
						state_q <= S_UPD;
					end else begin
						step_q  <= STEP_SQ_FIRST;
						state_q <= S_MUL;
					end
				end
				S_DIV: begin
					if (div_stat.done) begin
						state_q <= S_SUB;
					end
				end
				S_SUB: begin
					state_q <= S_UPD;
				end
				S_UPD: begin
					// strict compare: earlier edge keeps a tie
					if ((edge_idx_q == '0) || (res_q < best_dist_q)) begin
						best_dist_q <= res_q;
						best_edge_q <= edge_idx_q;
					end
					state_q <= S_TAIL;
				end
				S_TAIL: begin
					if (!last_q) begin
						state_q <= S_IDLE;
					end else if (close_go) begin
						closing_q <= 1'b1;
						state_q   <= S_DIFF;
					end else if (out_free) begin
						count_q     <= '0;
						ovf_q       <= 1'b0;
						closing_q   <= 1'b0;
						state_q     <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (start_path) begin
			query_q <= in_qry;
			start_q <= in_vtx;
			prev_q  <= in_vtx;
		end
		if (take_vtx) begin
			edge_a_q   <= prev_q;
			edge_b_q   <= in_vtx;
			edge_idx_q <= count_q[IDX_W-1:0] - 1'b1;
			prev_q     <= in_vtx;
		end
		if (close_go) begin
			edge_a_q   <= prev_q;
			edge_b_q   <= start_q;
			edge_idx_q <= count_q[IDX_W-1:0] - 1'b1;
		end
		if (state_q == S_DIFF) begin
			d_q <= sub_pt(query_q, edge_a_q);
			e_q <= sub_pt(edge_b_q, edge_a_q);
			f_q <= sub_pt(query_q, edge_b_q);
		end
		if (mac_stat.done) begin
			case (mac_stat.dest)
				DST_LEN: len2_q <= mac_acc[DIST_W-1:0];
				DST_DOT: dot_q  <= mac_acc[DOT_W-1:0];
				DST_DD:  dd_q   <= mac_acc[DIST_W-1:0];
				DST_DB:  db_q   <= mac_acc[DIST_W-1:0];
				default: ;
			endcase
		end
		if (state_q == S_PICK) begin
			res_q <= ((len2_q == '0) || dot_nonpos) ? dd_q : db_q;
		end
		if (state_q == S_SUB) begin
			res_q <= dd_q - quot;
		end
		if (out_load) begin
			out_word_q.found            <= found;
			out_word_q.nearest_edge     <= found ? best_edge_q : '0;
			out_word_q.distance_squared <= found ? best_dist_q : '0;
			out_word_q.overflow         <= ovf_q;
		end
	end

	assign out_valid = out_valid_q;
	assign out_word  = out_word_q;

	`NPES_ASSERT_NXT(a_result_ends_path, out_load, (count_q == '0) && !ovf_q && !closing_q)
	`NPES_ASSERT_IMP(a_best_edge_in_path, out_load && found, {1'b0, best_edge_q} < count_q)
	`NPES_ASSERT_IMP(a_div_mac_exclusive, div_stat.busy, !mac_stat.done && !mac_ctl.vld)
	`NPES_ASSERT_IMP(a_div_runs_in_state, state_q == S_DIV, div_stat.busy || div_stat.done)

endmodule

// ----- dv/tb.sv -----
// Testbench for nearest_path_edge_search_core: directed rows, random paths, then a capacity run.
// Keeps its own model of the nearest edge search and checks every result word.
// Depends on npes_pkg and the core RTL.
module tb;
	import npes_pkg::*;

	localparam longint unsigned DIST_SAT = (64'd1 << DIST_W) - 64'd1;
	localparam int DRAIN_CYCLES = 150;
	localparam int HOLD_OFF_CYCLES = 600;

	typedef struct {
		longint x;
		longint y;
		longint z;
	} pt3_t;

	typedef struct {
		bit        closed;
		bit        typed;
		in_word_t  word;
		out_word_t want;
	} dir_row_t;

	logic      clk;
	logic      arst_n;
	logic      cfg_we;
	logic      cfg_wdata;
	logic      in_valid;
	logic      in_ready;
	in_word_t  in_word;
	logic      out_valid;
	logic      out_ready;
	out_word_t out_word;

	// model state
	pt3_t            query_pt;
	pt3_t            path_first;
	pt3_t            path_prev;
	longint unsigned near_dist;
	int              near_seg;
	int              path_len;
	bit              path_over;
	bit              closing_on;

	out_word_t pending_results[$];
	dir_row_t  dir_rows[$];
	int        errs;
	int        results_seen;
	bit        send_burst;

	nearest_path_edge_search_core dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_word   (in_word),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_word  (out_word)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin : watchdog
		#40_000_000;
		$display("simulation failed");
		$finish;
	end

	function automatic longint unsigned seg_dist2(input pt3_t a, input pt3_t b);
		longint dx, dy, dz, ex, ey, ez, dot, fx, fy, fz;
		longint unsigned len2, dd, r;
		logic [127:0] num, den;
		dx = query_pt.x - a.x;
		dy = query_pt.y - a.y;
		dz = query_pt.z - a.z;
		ex = b.x - a.x;
		ey = b.y - a.y;
		ez = b.z - a.z;
		len2 = ex * ex + ey * ey + ez * ez;
		dd = dx * dx + dy * dy + dz * dz;
		dot = dx * ex + dy * ey + dz * ez;
		if (len2 == 0 || dot <= 0) begin
			r = dd;
		end else if ($unsigned(dot) >= len2) begin
			fx = query_pt.x - b.x;
			fy = query_pt.y - b.y;
			fz = query_pt.z - b.z;
			r = fx * fx + fy * fy + fz * fz;
		end else begin
			// projection falls inside the segment: exact floor of dot^2 / len2
			num = 128'(dot);
			num = num * num;
			den = 128'(len2);
			r = dd - 64'(num / den);
		end
		if (r > DIST_SAT)
			r = DIST_SAT;
		return r;
	endfunction

	function automatic void keep_nearest(input longint unsigned d, input int idx);
		if (idx == 0 || d < near_dist) begin
			near_dist = d;
			near_seg = idx;
		end
	endfunction

	// advance the model by one accepted word; 1 when a result word follows
	function automatic bit trace_vertex(input in_word_t w, output out_word_t r);
		pt3_t v;
		v.x = longint'($signed(w.vertex_x));
		v.y = longint'($signed(w.vertex_y));
		v.z = longint'($signed(w.vertex_z));
		r = '0;
		if (w.first_point || path_len == 0) begin
			query_pt.x = longint'($signed(w.query_x));
			query_pt.y = longint'($signed(w.query_y));
			query_pt.z = longint'($signed(w.query_z));
			path_first = v;
			path_prev = v;
			path_len = 1;
			near_dist = 0;
			near_seg = 0;
			path_over = 1'b0;
		end else if (path_len < MAX_VERTICES) begin
			keep_nearest(seg_dist2(path_prev, v), path_len - 1);
			path_prev = v;
			path_len++;
		end else begin
			path_over = 1'b1;
		end
		if (!w.last_point)
			return 1'b0;
		if (closing_on && path_len >= 2)
			keep_nearest(seg_dist2(path_prev, path_first), path_len - 1);
		if (path_len >= 2) begin
			r.found = 1'b1;
			r.nearest_edge = IDX_W'(near_seg);
			r.distance_squared = DIST_W'(near_dist);
		end
		r.overflow = path_over;
		path_len = 0;
		path_over = 1'b0;
		return 1'b1;
	endfunction

	function automatic in_word_t vtx(input int vx, input int vy, input int vz,
			input int qx, input int qy, input int qz, input bit f, input bit l);
		in_word_t w;
		w.vertex_x = 16'(vx);
		w.vertex_y = 16'(vy);
		w.vertex_z = 16'(vz);
		w.query_x = 16'(qx);
		w.query_y = 16'(qy);
		w.query_z = 16'(qz);
		w.first_point = f;
		w.last_point = l;
		return w;
	endfunction

	function automatic out_word_t res(input bit f, input int idx, input longint unsigned d,
			input bit ovf);
		out_word_t r;
		r.found = f;
		r.nearest_edge = IDX_W'(idx);
		r.distance_squared = DIST_W'(d);
		r.overflow = ovf;
		return r;
	endfunction

	function automatic void add_row(input bit closed, input in_word_t w, input bit typed,
			input out_word_t want);
		dir_row_t row;
		row.closed = closed;
		row.word = w;
		row.typed = typed;
		row.want = want;
		dir_rows.push_back(row);
	endfunction

	function automatic logic [15:0] rnd_coord(input int style);
		case (style)
			0: return 16'($urandom_range(0, 80) - 40);
			1: return 16'($urandom);
			2: begin
				case ($urandom_range(0, 3))
					0: return 16'h8000;
					1: return 16'h7fff;
					2: return 16'h0000;
					default: return 16'hffff;
				endcase
			end
			default: return 16'($urandom_range(0, 4000) - 2000);
		endcase
	endfunction

	// offer one word, wait for the handshake, then log what it should produce
	task automatic send_word(input in_word_t w, input bit typed, input out_word_t want);
		int gap;
		out_word_t r;
		gap = send_burst ? 0 : $urandom_range(0, 4);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_word <= w;
		in_valid <= 1'b1;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		if (trace_vertex(w, r))
			pending_results.push_back(typed ? want : r);
		@(negedge clk);
	endtask

	// block must be idle: every result out, then a margin for a trailing pass
	task automatic set_closed(input bit v);
		in_valid <= 1'b0;
		while (pending_results.size() != 0) @(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
		cfg_wdata <= v;
		cfg_we <= 1'b1;
		@(negedge clk);
		cfg_we <= 1'b0;
		closing_on = v;
	endtask

	initial begin : result_check
		int gap;
		bit rcv_burst;
		out_word_t want;
		out_ready = 1'b0;
		rcv_burst = 1'b0;
		results_seen = 0;
		wait (arst_n === 1'b1);
		@(negedge clk);
		forever begin
			if ($urandom_range(0, 7) == 0)
				rcv_burst = ~rcv_burst;
			gap = rcv_burst ? 0 : $urandom_range(0, 4);
			// one long hold-off so the core backs up into its input
			if (results_seen == 30)
				gap = HOLD_OFF_CYCLES;
			if (gap > 0) begin
				out_ready <= 1'b0;
				repeat (gap) @(negedge clk);
			end
			out_ready <= 1'b1;
			@(posedge clk);
			while (!out_valid) @(posedge clk);
			results_seen++;
			if (pending_results.size() == 0) begin
				$display("%0t: unexpected result word %h", $time, out_word);
				errs++;
			end else begin
				want = pending_results.pop_front();
				if (out_word.found !== want.found) begin
					$display("%0t: found expected %0d, got %0d", $time,
						want.found, out_word.found);
					errs++;
				end
				if (out_word.nearest_edge !== want.nearest_edge) begin
					$display("%0t: nearest_edge expected %0d, got %0d", $time,
						want.nearest_edge, out_word.nearest_edge);
					errs++;
				end
				if (out_word.distance_squared !== want.distance_squared) begin
					$display("%0t: distance_squared expected %0d, got %0d", $time,
						want.distance_squared, out_word.distance_squared);
					errs++;
				end
				if (out_word.overflow !== want.overflow) begin
					$display("%0t: overflow expected %0d, got %0d", $time,
						want.overflow, out_word.overflow);
					errs++;
				end
			end
			@(negedge clk);
		end
	end

	initial begin : stim
		in_word_t w;
		out_word_t none;
		int len, cst, qst, sent;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_wdata = 1'b0;
		in_valid = 1'b0;
		in_word = '0;
		errs = 0;
		send_burst = 1'b0;
		none = '0;
		query_pt = '{0, 0, 0};
		path_first = '{0, 0, 0};
		path_prev = '{0, 0, 0};
		near_dist = 0;
		near_seg = 0;
		path_len = 0;
		path_over = 1'b0;
		closing_on = 1'b0;

		// open path rows
		// lone vertex right after reset, no first_point: starts and ends a path
		add_row(0, vtx(0, 0, 0, 0, 0, 0, 0, 1), 1, res(0, 0, 0, 0));
		// zero-length edge at one corner, query at the opposite corner
		add_row(0, vtx(-32768, -32768, -32768, 32767, 32767, 32767, 1, 0), 0, none);
		add_row(0, vtx(-32768, -32768, -32768, 0, 0, 0, 0, 1), 1,
			res(1, 0, 64'd12884508675, 0));
		add_row(0, vtx(0, 0, 0, 5, 7, -3, 1, 0), 0, none);
		add_row(0, vtx(100, 0, 0, 0, 0, 0, 0, 0), 0, none);
		add_row(0, vtx(100, 100, 0, 0, 0, 0, 0, 0), 0, none);
		add_row(0, vtx(-20, 50, 9, 0, 0, 0, 0, 1), 0, none);
		// restart in mid path drops the first two vertices
		add_row(0, vtx(1, 1, 1, 0, 0, 0, 1, 0), 0, none);
		add_row(0, vtx(2, 2, 2, 0, 0, 0, 0, 0), 0, none);
		add_row(0, vtx(10, 0, 0, 3, 4, 0, 1, 0), 0, none);
		add_row(0, vtx(10, 10, 0, 0, 0, 0, 0, 0), 0, none);
		add_row(0, vtx(-10, 10, 0, 0, 0, 0, 0, 1), 0, none);
		// equal distances on both edges: the earlier one stays
		add_row(0, vtx(-5, 0, 0, 0, 3, 0, 1, 0), 0, none);
		add_row(0, vtx(5, 0, 0, 0, 0, 0, 0, 0), 0, none);
		add_row(0, vtx(-5, 0, 0, 0, 0, 0, 0, 1), 1, res(1, 0, 9, 0));
		add_row(0, vtx(7, 7, 7, 7, 7, 7, 1, 0), 0, none);
		add_row(0, vtx(7, 7, 7, 0, 0, 0, 0, 1), 1, res(1, 0, 0, 0));
		// projection behind the start point
		add_row(0, vtx(0, 0, 0, -3, 0, 0, 1, 0), 0, none);
		add_row(0, vtx(10, 0, 0, 0, 0, 0, 0, 1), 1, res(1, 0, 9, 0));
		// closed rows: two-vertex polygon, closing edge wins, lone vertex
		add_row(1, vtx(-5, 0, 0, 0, 3, 0, 1, 0), 0, none);
		add_row(1, vtx(5, 0, 0, 0, 0, 0, 0, 1), 1, res(1, 0, 9, 0));
		add_row(1, vtx(0, 0, 0, 50, -2, 0, 1, 0), 0, none);
		add_row(1, vtx(0, 100, 0, 0, 0, 0, 0, 0), 0, none);
		add_row(1, vtx(100, 100, 0, 0, 0, 0, 0, 1), 0, none);
		add_row(1, vtx(1, 2, 3, 4, 5, 6, 1, 1), 1, res(0, 0, 0, 0));

		repeat (11) @(negedge clk);
		arst_n <= 1'b1;
		set_closed(1'b0);

		foreach (dir_rows[i]) begin
			if (dir_rows[i].closed != closing_on)
				set_closed(dir_rows[i].closed);
			send_word(dir_rows[i].word, dir_rows[i].typed, dir_rows[i].want);
		end

		// random paths, alternating open and closed phases
		for (int ph = 0; ph < 8; ph++) begin
			set_closed(ph[0]);
			sent = 0;
			while (sent < 200) begin
				case ($urandom_range(0, 9))
					0: len = 1;
					9: len = $urandom_range(9, 40);
					default: len = $urandom_range(2, 8);
				endcase
				cst = $urandom_range(0, 3);
				qst = $urandom_range(0, 3);
				send_burst = ($urandom_range(0, 3) == 0);
				w = '0;
				for (int k = 0; k < len; k++) begin
					// now and then repeat the last vertex for a zero-length edge
					if (k == 0 || $urandom_range(0, 19) != 0) begin
						w.vertex_x = rnd_coord(cst);
						w.vertex_y = rnd_coord(cst);
						w.vertex_z = rnd_coord(cst);
					end
					w.query_x = (k == 0) ? rnd_coord(qst) : 16'($urandom);
					w.query_y = (k == 0) ? rnd_coord(qst) : 16'($urandom);
					w.query_z = (k == 0) ? rnd_coord(qst) : 16'($urandom);
					w.first_point = (k == 0) ? ($urandom_range(0, 4) != 0)
						: ($urandom_range(0, 29) == 0);
					w.last_point = (k == len - 1) || ($urandom_range(0, 39) == 0);
					send_word(w, 0, none);
					sent++;
				end
			end
		end

		// capacity: closing edge through the query gets the top index,
		// the words past capacity are dropped
		set_closed(1'b1);
		send_burst = 1'b0;
		for (int k = 0; k < MAX_VERTICES + 4; k++) begin
			w = '0;
			if (k == 0) begin
				w.vertex_x = -16'sd1000;
			end else if (k == MAX_VERTICES - 1) begin
				w.vertex_x = 16'sd1000;
			end else begin
				w.vertex_x = 16'($urandom_range(0, 2000) - 1000);
				w.vertex_y = 16'($urandom_range(0, 2000) - 1000);
				w.vertex_z = 16'($urandom_range(500, 600));
				w.query_x = 16'($urandom);
				w.query_y = 16'($urandom);
				w.query_z = 16'($urandom);
			end
			w.first_point = (k == 0);
			w.last_point = (k == MAX_VERTICES + 3);
			send_word(w, 0, none);
		end
		set_closed(1'b0);
		send_word(vtx(3, -4, 5, 0, 0, 0, 1, 0), 0, none);
		send_word(vtx(-3, 4, -5, 1, 1, 1, 0, 1), 0, none);

		in_valid <= 1'b0;
		while (pending_results.size() != 0) @(negedge clk);
		repeat (200) @(negedge clk);
		if (errs == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule
